// ----- rtl/core/odq_pkg.sv -----
// ----------------------------------------------------------------------------
// odq_pkg
// Shared types, codes and slot arithmetic for the ordered record deque.
// ----------------------------------------------------------------------------
package odq_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 16;

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = $clog2(2 * DEPTH);
    localparam int WORD_W = 16;

    localparam logic [WORD_W-1:0] KEY_MASK = WORD_W'((64'd1 << KEY_BITS) - 64'd1);

    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] pa;
        logic [WORD_W-1:0] pb;
    } rec_t;

    localparam rec_t REC_ZERO = '{key: '0, pa: '0, pb: '0};

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        rec_t              wdata;
        logic [SLOT_W-1:0] raddr;
    } ram_req_t;

    typedef enum logic [2:0] {
        F_PUSH_BACK  = 3'd0,
        F_PUSH_FRONT = 3'd1,
        F_POP_FRONT  = 3'd2,
        F_POP_BACK   = 3'd3,
        F_REMOVE     = 3'd4,
        F_CONTAINS   = 3'd5,
        F_LIST       = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_WALK,
        S_SHIFT
    } state_t;

    // store slot of a position counted from the front
    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] front,
                                                  input logic [CNT_W-1:0]  pos);
        logic [SUM_W-1:0] s;
        s = SUM_W'(front) + SUM_W'(pos);
        if (s >= SUM_W'(DEPTH))
            s = s - SUM_W'(DEPTH);
        return s[SLOT_W-1:0];
    endfunction

endpackage

// ----- rtl/core/odq_ram.sv -----
// ----------------------------------------------------------------------------
// odq_ram
// Record store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module odq_ram
    import odq_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output rec_t     rdata
);

    rec_t mem [DEPTH];
    rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/ordered_deque_with_key_removal.sv -----
// ----------------------------------------------------------------------------
// ordered_deque_with_key_removal
// Bounded deque of key/payload records with push, pop, remove by key,
// contains and list, walked one record per cycle over a single record store.
// Push needs no walk, pop reads the end record; contains, remove and list
// walk from the front, remove stops at the first match and shifts the later
// records one place toward the front. One transfer at a time; busy stays
// high during the walk (one entry read per cycle); results cannot be stalled.
// Reset: asynchronous, clears count and front slot; store contents undefined.
// ----------------------------------------------------------------------------
module ordered_deque_with_key_removal
    import odq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        func,
    input  logic [WORD_W-1:0] key,
    input  logic [WORD_W-1:0] payload_a,
    input  logic [WORD_W-1:0] payload_b,
    output logic              strobe,
    output logic [WORD_W-1:0] key_out,
    output logic [WORD_W-1:0] payload_a_out,
    output logic [WORD_W-1:0] payload_b_out,
    output logic              found,
    output logic [1:0]        status,
    output logic [4:0]        occupancy,
    output logic              last
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    func_t             func_reg, func_next;
    logic [WORD_W-1:0] key_reg, key_next;
    rec_t              hold_reg, hold_next;

    logic              strobe_reg, strobe_next;
    rec_t              res_rec_reg, res_rec_next;
    logic              found_reg, found_next;
    status_t           status_reg, status_next;
    logic [CNT_W-1:0]  occ_reg;
    logic              last_reg, last_next;

    ram_req_t          ram_req;
    rec_t              rdata;
    rec_t              in_rec;
    logic              accept;
    logic              full;
    logic              hit;
    logic              at_back;

    odq_ram u_ram
    (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    assign accept  = start && !busy;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign hit     = (rdata.key == key_reg);
    assign at_back = (pos_reg + CNT_W'(1) == count_reg);
    assign in_rec  = '{key: key & KEY_MASK, pa: payload_a, pb: payload_b};

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        front_next   = front_reg;
        pos_next     = pos_reg + CNT_W'(1);
        func_next    = func_reg;
        key_next     = key_reg;
        hold_next    = hold_reg;
        strobe_next  = 1'b0;
        res_rec_next = REC_ZERO;
        found_next   = 1'b0;
        status_next  = ST_OK;
        last_next    = 1'b1;
        ram_req.we    = 1'b0;
        ram_req.waddr = slot_of(front_reg, count_reg);
        ram_req.wdata = in_rec;
        ram_req.raddr = slot_of(front_reg, pos_reg + CNT_W'(1));

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next = func_t'(func);
                    key_next  = in_rec.key;
                    pos_next  = '0;
                    strobe_next = 1'b1;
                    unique case (func_t'(func))
                        F_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_req.we = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        F_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                front_next = (front_reg == '0) ? SLOT_W'(DEPTH - 1)
                                                               : front_reg - SLOT_W'(1);
                                ram_req.we    = 1'b1;
                                ram_req.waddr = front_next;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        F_POP_FRONT, F_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_MISS;
                            end
                            else
                            begin
                                strobe_next = 1'b0;
                                count_next  = count_reg - CNT_W'(1);
                                state_next  = S_POP;
                                if (func_t'(func) == F_POP_FRONT)
                                begin
                                    ram_req.raddr = front_reg;
                                    front_next    = slot_of(front_reg, CNT_W'(1));
                                end
                                else
                                begin
                                    ram_req.raddr = slot_of(front_reg,
                                                            count_reg - CNT_W'(1));
                                end
                            end
                        end
                        F_REMOVE, F_CONTAINS, F_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_MISS;
                            end
                            else
                            begin
                                strobe_next   = 1'b0;
                                ram_req.raddr = front_reg;
                                state_next    = S_WALK;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                strobe_next  = 1'b1;
                res_rec_next = rdata;
                found_next   = 1'b1;
                state_next   = S_IDLE;
            end
            S_WALK:
            begin
                unique case (func_reg)
                    F_LIST:
                    begin
                        strobe_next  = 1'b1;
                        res_rec_next = rdata;
                        found_next   = 1'b1;
                        last_next    = at_back;
                        if (at_back)
                            state_next = S_IDLE;
                    end
                    F_CONTAINS:
                    begin
                        if (hit)
                        begin
                            strobe_next = 1'b1;
                            found_next  = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else if (at_back)
                        begin
                            strobe_next = 1'b1;
                            status_next = ST_MISS;
                            state_next  = S_IDLE;
                        end
                    end
                    F_REMOVE:
                    begin
                        if (hit && at_back)
                        begin
                            strobe_next  = 1'b1;
                            res_rec_next = rdata;
                            found_next   = 1'b1;
                            count_next   = count_reg - CNT_W'(1);
                            state_next   = S_IDLE;
                        end
                        else if (hit)
                        begin
                            // later records move one place toward the front
                            hold_next  = rdata;
                            state_next = S_SHIFT;
                        end
                        else if (at_back)
                        begin
                            strobe_next = 1'b1;
                            status_next = ST_MISS;
                            state_next  = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SHIFT:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = slot_of(front_reg, pos_reg - CNT_W'(1));
                ram_req.wdata = rdata;
                if (at_back)
                begin
                    strobe_next  = 1'b1;
                    res_rec_next = hold_reg;
                    found_next   = 1'b1;
                    count_next   = count_reg - CNT_W'(1);
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            front_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            front_reg  <= front_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        func_reg    <= func_next;
        key_reg     <= key_next;
        hold_reg    <= hold_next;
        res_rec_reg <= res_rec_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        occ_reg     <= count_next;
        last_reg    <= last_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign strobe        = strobe_reg;
    assign key_out       = res_rec_reg.key;
    assign payload_a_out = res_rec_reg.pa;
    assign payload_b_out = res_rec_reg.pb;
    assign found         = found_reg;
    assign status        = status_reg;
    assign occupancy     = 5'(occ_reg);
    assign last          = last_reg;

    // every final result leaves the sequencer idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && last_reg |-> state_reg == S_IDLE)
        else $error("final result while sequencer still running");

    // only a list transfer produces non-final results
    a_multi_list: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !last_reg |-> func_reg == F_LIST)
        else $error("non-final result outside list");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("record count above depth");

    // an accepted push with room grows the count by one
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (func == F_PUSH_BACK || func == F_PUSH_FRONT) && !full
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not grow count");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> (status_reg == ST_OK || status_reg == ST_MISS
                        || status_reg == ST_FULL) && occ_reg == count_reg)
        else $error("bad status or occupancy on result");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered record deque: drives corner cases, then
// push, pop, remove, contains and list commands in random bursts, tracks a
// mirror of the deque and compares every strobed response field by field in order.
// ----------------------------------------------------------------------------
module tb;
    import odq_pkg::*;

    localparam logic [2:0] FUNC_UNUSED = 3'd7;
    localparam int         IDLE_LIMIT  = 2000;
    localparam int         DRAIN_WAIT  = 40;
    localparam int         RANDOM_CMDS = 96;

    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] pa;
        logic [WORD_W-1:0] pb;
        logic              found;
        logic [1:0]        status;
        logic [4:0]        occupancy;
        logic              last;
    } reply_t;

    class deque_tracker;
        rec_t        mirror_store [DEPTH];
        int unsigned mirror_front;
        int unsigned mirror_count;
        reply_t      pending_replies [$];
        int unsigned mismatches;

        function new();
            mirror_front = 0;
            mirror_count = 0;
            mismatches   = 0;
        endfunction

        function int unsigned slot(int unsigned pos);
            return (mirror_front + pos) % DEPTH;
        endfunction

        // occupancy is taken after the state update
        function void add_reply(rec_t r, logic fnd, logic [1:0] st, logic lst);
            reply_t e;
            e.key       = r.key;
            e.pa        = r.pa;
            e.pb        = r.pb;
            e.found     = fnd;
            e.status    = st;
            e.occupancy = 5'(mirror_count);
            e.last      = lst;
            pending_replies.push_back(e);
        endfunction

        function void note_command(logic [2:0] fn, logic [WORD_W-1:0] k,
                                   logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
            rec_t        r;
            int unsigned pos;
            bit          hit;
            r.key = k & KEY_MASK;
            r.pa  = a;
            r.pb  = b;
            case (fn)
                F_PUSH_BACK, F_PUSH_FRONT:
                begin
                    if (mirror_count >= DEPTH)
                        add_reply(REC_ZERO, 1'b0, ST_FULL, 1'b1);
                    else
                    begin
                        if (fn == F_PUSH_BACK)
                            mirror_store[slot(mirror_count)] = r;
                        else
                        begin
                            mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
                            mirror_store[mirror_front] = r;
                        end
                        mirror_count++;
                        add_reply(REC_ZERO, 1'b0, ST_OK, 1'b1);
                    end
                end
                F_POP_FRONT, F_POP_BACK:
                begin
                    if (mirror_count == 0)
                        add_reply(REC_ZERO, 1'b0, ST_MISS, 1'b1);
                    else
                    begin
                        if (fn == F_POP_FRONT)
                        begin
                            r = mirror_store[slot(0)];
                            mirror_front = slot(1);
                        end
                        else
                            r = mirror_store[slot(mirror_count - 1)];
                        mirror_count--;
                        add_reply(r, 1'b1, ST_OK, 1'b1);
                    end
                end
                F_REMOVE, F_CONTAINS:
                begin
                    hit = 1'b0;
                    pos = 0;
                    for (int unsigned i = 0; i < mirror_count; i++)
                    begin
                        if (!hit && mirror_store[slot(i)].key == r.key)
                        begin
                            hit = 1'b1;
                            pos = i;
                        end
                    end
                    if (!hit)
                        add_reply(REC_ZERO, 1'b0, ST_MISS, 1'b1);
                    else if (fn == F_CONTAINS)
                        add_reply(REC_ZERO, 1'b1, ST_OK, 1'b1);
                    else
                    begin
                        r = mirror_store[slot(pos)];
                        // later records close the gap toward the front
                        for (int unsigned i = pos; i + 1 < mirror_count; i++)
                            mirror_store[slot(i)] = mirror_store[slot(i + 1)];
                        mirror_count--;
                        add_reply(r, 1'b1, ST_OK, 1'b1);
                    end
                end
                F_LIST:
                begin
                    if (mirror_count == 0)
                        add_reply(REC_ZERO, 1'b0, ST_MISS, 1'b1);
                    else
                        for (int unsigned i = 0; i < mirror_count; i++)
                            add_reply(mirror_store[slot(i)], 1'b1, ST_OK,
                                      (i + 1 == mirror_count));
                end
                default:
                    add_reply(REC_ZERO, 1'b0, ST_OK, 1'b1);
            endcase
        endfunction

        function void check_response(reply_t got);
            reply_t exp;
            if (pending_replies.size() == 0)
            begin
                if (mismatches < 10)
                    $display({"[%0t] response with none pending: ",
                              "key %h a %h b %h f %b st %0d occ %0d last %b"},
                             $time, got.key, got.pa, got.pb, got.found, got.status,
                             got.occupancy, got.last);
                mismatches++;
                return;
            end
            exp = pending_replies.pop_front();
            if (got !== exp)
            begin
                if (mismatches < 10)
                begin
                    $display({"[%0t] mismatch expected: ",
                              "key %h a %h b %h f %b st %0d occ %0d last %b"},
                             $time, exp.key, exp.pa, exp.pb, exp.found, exp.status,
                             exp.occupancy, exp.last);
                    $display({"[%0t] mismatch actual:   ",
                              "key %h a %h b %h f %b st %0d occ %0d last %b"},
                             $time, got.key, got.pa, got.pb, got.found, got.status,
                             got.occupancy, got.last);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic [2:0]        func      = '0;
    logic [WORD_W-1:0] key       = '0;
    logic [WORD_W-1:0] payload_a = '0;
    logic [WORD_W-1:0] payload_b = '0;
    logic              busy;
    logic              strobe;
    logic [WORD_W-1:0] key_out;
    logic [WORD_W-1:0] payload_a_out;
    logic [WORD_W-1:0] payload_b_out;
    logic              found;
    logic [1:0]        status;
    logic [4:0]        occupancy;
    logic              last;

    deque_tracker      tracker;
    logic [WORD_W-1:0] key_pool [8];
    int                idle_cycles;

    ordered_deque_with_key_removal u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .key           (key),
        .payload_a     (payload_a),
        .payload_b     (payload_b),
        .strobe        (strobe),
        .key_out       (key_out),
        .payload_a_out (payload_a_out),
        .payload_b_out (payload_b_out),
        .found         (found),
        .status        (status),
        .occupancy     (occupancy),
        .last          (last)
    );

    always #4 clk = ~clk;

    // start stays high across back-to-back transfers
    task send_command(input logic [2:0] fn, input logic [WORD_W-1:0] k,
                      input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
        func      <= fn;
        key       <= k;
        payload_a <= a;
        payload_b <= b;
        start     <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_command(fn, k, a, b);
    endtask

    task pause_sender(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            tracker.check_response('{key: key_out, pa: payload_a_out, pb: payload_b_out,
                                     found: found, status: status,
                                     occupancy: occupancy, last: last});
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((start && !busy) || strobe)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [2:0]        fn;
        logic [WORD_W-1:0] k;
        int                sent;
        int                burst;
        int                pick;
        bit                filling;

        tracker = new();
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 8; i++)
            key_pool[i] = WORD_W'($urandom);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store corner cases
        send_command(F_POP_FRONT, 16'h0000, 16'h0000, 16'h0000);
        send_command(F_POP_BACK, 16'hffff, 16'hffff, 16'hffff);
        send_command(F_REMOVE, key_pool[2], 16'h0000, 16'h0000);
        pause_sender(3);
        send_command(F_CONTAINS, key_pool[3], 16'h0000, 16'h0000);
        send_command(F_LIST, 16'h0000, 16'h0000, 16'h0000);
        send_command(FUNC_UNUSED, 16'hffff, 16'hffff, 16'hffff);

        // fill from both ends, with duplicate keys, then overflow
        for (int i = 0; i < DEPTH; i++)
        begin
            fn = i[0] ? F_PUSH_FRONT : F_PUSH_BACK;
            if (i == 0)
                send_command(fn, 16'h0000, 16'h0000, 16'h0000);
            else if (i == 1)
                send_command(fn, 16'hffff, 16'hffff, 16'hffff);
            else
                send_command(fn, key_pool[i % 8], WORD_W'($urandom), WORD_W'($urandom));
            if (i % 5 == 4)
                pause_sender($urandom_range(1, 4));
        end
        send_command(F_PUSH_BACK, 16'h5a5a, 16'ha5a5, 16'h0f0f);
        send_command(F_PUSH_FRONT, 16'ha5a5, 16'h5a5a, 16'hf0f0);
        send_command(F_LIST, 16'h0000, 16'h0000, 16'h0000);

        sent    = 0;
        filling = 1'b0;
        while (sent < RANDOM_CMDS)
        begin
            burst = $urandom_range(1, 8);
            for (int j = 0; j < burst; j++)
            begin
                if (tracker.mirror_count >= DEPTH)
                    filling = 1'b0;
                else if (tracker.mirror_count == 0)
                    filling = 1'b1;
                else if ($urandom_range(0, 19) == 0)
                    filling = !filling;
                pick = $urandom_range(0, 99);
                if (filling)
                    fn = (pick < 35) ? F_PUSH_BACK : (pick < 60) ? F_PUSH_FRONT :
                         (pick < 68) ? F_POP_FRONT : (pick < 74) ? F_POP_BACK :
                         (pick < 82) ? F_REMOVE : (pick < 90) ? F_CONTAINS :
                         (pick < 97) ? F_LIST : FUNC_UNUSED;
                else
                    fn = (pick < 10) ? F_PUSH_BACK : (pick < 20) ? F_PUSH_FRONT :
                         (pick < 40) ? F_POP_FRONT : (pick < 55) ? F_POP_BACK :
                         (pick < 78) ? F_REMOVE : (pick < 88) ? F_CONTAINS :
                         (pick < 96) ? F_LIST : FUNC_UNUSED;
                // mostly pooled keys so remove and contains hit, duplicates included
                if ($urandom_range(0, 3) == 0)
                    k = WORD_W'($urandom);
                else
                    k = key_pool[$urandom_range(0, 7)];
                send_command(fn, k, WORD_W'($urandom), WORD_W'($urandom));
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
        end

        pause_sender(1);
        while (tracker.pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        tracker.mismatches += tracker.pending_replies.size();

        if (tracker.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
